### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

### src/rufa_pkg.sv
// ----------------------------------------------------------------------------
// rufa_pkg
// types and constants of the resource unit first-fit allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rufa_pkg;

    localparam int NUM_REGS  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int UNITS_W   = 7;
    localparam int IN_TIME_W = 32;
    localparam int OUT_IDX_W = 6;
    localparam logic [UNITS_W-1:0] UNITS_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_ZERO    = 2'd1,
        ST_SHORT   = 2'd2
    } rufa_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_COUNT,
        S_DECIDE,
        S_GRANT,
        S_ERROR
    } rufa_state_t;

    typedef struct packed {
        logic [1:0]           res_id;
        logic [IN_TIME_W-1:0] job_start;
        logic [UNITS_W-1:0]   units_wanted;
        logic [IN_TIME_W-1:0] duration;
    } rufa_in_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] unit_index;
        rufa_status_t         status;
        logic                 last;
    } rufa_out_t;

endpackage

### src/rufa_ram.sv
// ----------------------------------------------------------------------------
// rufa_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rufa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/resource_unit_first_fit_allocator_top.sv
// flow: a check state, one pass reading the free-time ram, one unit per cycle over the
// n units of its resource, a decide state, then a grant pass that steps one unit per
// cycle, writing each free one, holds on a free unit while the result register waits
// on m_ready and stops at the last granted unit; error results also wait on m_ready
// throughput: one request at a time, the ram read port sets the scan rate
// reset: aresetn synchronous active low; then a pass clears all free-time ram entries
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// resource_unit_first_fit_allocator_top
// first-fit allocator of resource units by free time; a result per granted unit or error
// ----------------------------------------------------------------------------

module resource_unit_first_fit_allocator_top
    import rufa_pkg::*;
#(
    parameter int NUM_RESOURCES = 4,
    parameter int MAX_UNITS     = 64,
    parameter int TIME_BITS     = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rufa_in_t             s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rufa_out_t            m_payload,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [UNITS_W-1:0]   cfg_wdata
);

    localparam int UIDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int UCNT_W = $clog2(MAX_UNITS + 1);
    localparam int RES_AW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int AW     = RES_AW + UIDX_W;
    localparam int IW     = (TIME_BITS > IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    localparam int SW     = TIME_BITS + 1;
    localparam logic [IW-1:0] TMAX_IW = IW'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [SW-1:0] TMAX_SW = SW'((64'd1 << TIME_BITS) - 64'd1);

    rufa_state_t state_reg, state_next;

    logic [UNITS_W-1:0]   units_reg [NUM_REGS];

    logic [AW-1:0]        clr_reg, clr_next;
    logic [1:0]           res_reg, res_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] dur_reg, dur_next;
    logic [TIME_BITS-1:0] end_reg, end_next;
    logic [UNITS_W-1:0]   want_reg, want_next;
    logic [UCNT_W-1:0]    n_reg, n_next;
    rufa_status_t         err_reg, err_next;
    logic [UCNT_W-1:0]    rd_u_reg, rd_u_next;
    logic                 pend_reg, pend_next;
    logic [UIDX_W-1:0]    pend_u_reg, pend_u_next;
    logic [UCNT_W-1:0]    cnt_reg, cnt_next;
    logic [MAX_UNITS-1:0] free_vec_reg, free_vec_next;
    logic [UCNT_W-1:0]    g_u_reg, g_u_next;
    logic [UCNT_W-1:0]    got_reg, got_next;
    logic                 m_valid_reg, m_valid_next;
    rufa_out_t            m_data_reg, m_data_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [TIME_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [TIME_BITS-1:0] mem_rdata;

    logic [IW-1:0]        start_in;
    logic [IW-1:0]        dur_in;
    logic [SW-1:0]        end_sum;
    logic [UNITS_W-1:0]   units_sel;
    logic [UNITS_W-1:0]   units_cap;
    logic                 res_ok;
    logic                 slot_free;
    logic                 unit_free;
    logic                 is_last;

    rufa_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (2 ** AW)
    ) u_free_time_ram (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                units_reg[i] <= UNITS_RESET;
            end
        end else if (cfg_wr_en) begin
            units_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        start_reg    <= start_next;
        dur_reg      <= dur_next;
        end_reg      <= end_next;
        want_reg     <= want_next;
        n_reg        <= n_next;
        err_reg      <= err_next;
        rd_u_reg     <= rd_u_next;
        pend_reg     <= pend_next;
        pend_u_reg   <= pend_u_next;
        cnt_reg      <= cnt_next;
        free_vec_reg <= free_vec_next;
        g_u_reg      <= g_u_next;
        got_reg      <= got_next;
        m_data_reg   <= m_data_next;
    end

    assign start_in  = IW'(s_payload.job_start);
    assign dur_in    = IW'(s_payload.duration);
    assign end_sum   = SW'(start_reg) + SW'(dur_reg);
    assign res_ok    = (32'(res_reg) < NUM_RESOURCES);
    assign units_sel = units_reg[res_reg];
    assign units_cap = (units_sel > UNITS_W'(MAX_UNITS)) ? UNITS_W'(MAX_UNITS) : units_sel;
    assign slot_free = !m_valid_reg || m_ready;
    assign unit_free = free_vec_reg[g_u_reg[UIDX_W-1:0]];
    assign is_last   = ((UNITS_W'(got_reg) + UNITS_W'(1)) == want_reg);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        res_next      = res_reg;
        start_next    = start_reg;
        dur_next      = dur_reg;
        end_next      = end_reg;
        want_next     = want_reg;
        n_next        = n_reg;
        err_next      = err_reg;
        rd_u_next     = rd_u_reg;
        pend_next     = 1'b0;
        pend_u_next   = pend_u_reg;
        cnt_next      = cnt_reg;
        free_vec_next = free_vec_reg;
        g_u_next      = g_u_reg;
        got_next      = got_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {RES_AW'(res_reg), g_u_reg[UIDX_W-1:0]};
        mem_wdata     = end_reg;
        mem_raddr     = {RES_AW'(res_reg), rd_u_reg[UIDX_W-1:0]};

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_next   = s_payload.res_id;
                    want_next  = s_payload.units_wanted;
                    start_next = (start_in > TMAX_IW) ? TIME_BITS'(TMAX_IW)
                                                      : TIME_BITS'(start_in);
                    dur_next   = (dur_in > TMAX_IW) ? TIME_BITS'(TMAX_IW)
                                                    : TIME_BITS'(dur_in);
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                end_next  = (end_sum > TMAX_SW) ? TIME_BITS'(TMAX_SW)
                                                : TIME_BITS'(end_sum);
                n_next    = res_ok ? UCNT_W'(units_cap) : '0;
                rd_u_next = '0;
                cnt_next  = '0;
                if (want_reg == '0 || dur_reg == '0) begin
                    err_next   = ST_ZERO;
                    state_next = S_ERROR;
                end else begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                // read issue and compare of the previous read overlap
                if (rd_u_reg != n_reg) begin
                    rd_u_next   = rd_u_reg + UCNT_W'(1);
                    pend_next   = 1'b1;
                    pend_u_next = rd_u_reg[UIDX_W-1:0];
                end
                if (pend_reg) begin
                    free_vec_next[pend_u_reg] = (mem_rdata <= start_reg);
                    cnt_next = cnt_reg + UCNT_W'(mem_rdata <= start_reg);
                end
                if (rd_u_reg == n_reg && !pend_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                g_u_next = '0;
                got_next = '0;
                if (UNITS_W'(cnt_reg) < want_reg) begin
                    err_next   = ST_SHORT;
                    state_next = S_ERROR;
                end else begin
                    state_next = S_GRANT;
                end
            end
            S_GRANT: begin
                if (!unit_free) begin
                    g_u_next = g_u_reg + UCNT_W'(1);
                end else if (slot_free) begin
                    mem_we                 = 1'b1;
                    m_valid_next           = 1'b1;
                    m_data_next.unit_index = OUT_IDX_W'(g_u_reg);
                    m_data_next.status     = ST_GRANTED;
                    m_data_next.last       = is_last;
                    g_u_next               = g_u_reg + UCNT_W'(1);
                    got_next               = got_reg + UCNT_W'(1);
                    if (is_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERROR: begin
                if (slot_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.unit_index = '0;
                    m_data_next.status     = err_reg;
                    m_data_next.last       = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // error transactions carry unit zero and close the request
    `ASSERT_CLK(a_err_result, aclk, aresetn, (m_valid && m_payload.status != ST_GRANTED) |-> (m_payload.last && m_payload.unit_index == '0), "error result not last or nonzero unit")
    // grant pass never goes past the requested count
    `ASSERT_CLK(a_grant_bound, aclk, aresetn, (state_reg == S_GRANT) |-> (UNITS_W'(got_reg) < want_reg), "grant count reached request")
    // free count cannot run ahead of issued reads
    `ASSERT_CLK(a_count_bound, aclk, aresetn, (state_reg == S_COUNT) |-> (cnt_reg <= rd_u_reg), "free count above scanned units")
    // nothing is accepted during the clearing pass
    `ASSERT_NEVER(a_clear_busy, aclk, aresetn, (state_reg == S_CLEAR) && s_ready, "ready during ram clear")

endmodule
